/* hw/rtl/iphp_pkg.sv */
`default_nettype none
package iphp_pkg;

    // Frame byte counter width
    localparam int COUNT_W = 16;
    typedef logic [COUNT_W-1:0] t_count;
    localparam t_count COUNT_MAX = '1;

    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1480;
    localparam int          MIN_HDR         = 20;

    // Fixed header byte offsets
    localparam int OFS_VER_IHL  = 0;
    localparam int OFS_TOTAL_HI = 2;
    localparam int OFS_TOTAL_LO = 3;
    localparam int OFS_TTL      = 8;
    localparam int OFS_PROTO    = 9;
    localparam int OFS_CSUM_HI  = 10;
    localparam int OFS_CSUM_LO  = 11;
    localparam int OFS_SRC_LO   = 12;
    localparam int OFS_SRC_HI   = 15;
    localparam int OFS_DST_LO   = 16;
    localparam int OFS_DST_HI   = 19;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;

    // Summary status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_VERSION    = 3'd2;
    localparam logic [2:0] ST_IHL        = 3'd3;
    localparam logic [2:0] ST_HDR_PAST   = 3'd4;
    localparam logic [2:0] ST_TOTAL_SHORT = 3'd5;
    localparam logic [2:0] ST_TOTAL_LONG = 3'd6;
    localparam logic [2:0] ST_PAY_LIMIT  = 3'd7;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] header_checksum;
        logic        checksum_ok;
        logic [15:0] payload_length;
        logic [5:0]  header_length;
    } t_summary;

    typedef struct packed {
        logic     has_pay;
        logic     has_sum;
        logic [7:0] pay_byte;
        t_summary summary;
    } t_entry;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        t_summary   summary;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/iphp_front.sv */
`default_nettype none
module iphp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_frame_last,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_full,
    output logic                   o_ready,
    output logic                   o_push,
    output iphp_pkg::t_entry       o_entry
);

    logic [15:0]      r_max_payload;
    iphp_pkg::t_count r_byte_count;
    logic [3:0]       r_version, r_ihl;
    logic [15:0]      r_total, r_csum;
    logic [7:0]       r_ttl, r_proto, r_hold;
    logic [31:0]      r_src, r_dst;
    logic [16:0]      r_sum;

    iphp_pkg::t_count pos, frame_len;
    logic             saturated, take, in_hdr, pay_ok, hdr_whole;
    logic [3:0]       n_version, n_ihl;
    logic [15:0]      n_total, n_csum, pay_len;
    logic [7:0]       n_ttl, n_proto, n_hold;
    logic [31:0]      n_src, n_dst;
    logic [16:0]      n_sum;
    logic [17:0]      sum_raw;
    logic [5:0]       hdr_len;
    logic [2:0]       status;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign pos     = r_byte_count;
    assign saturated = (pos == iphp_pkg::COUNT_MAX);

    always_comb begin
        n_version = r_version;
        n_ihl     = r_ihl;
        n_total   = r_total;
        n_ttl     = r_ttl;
        n_proto   = r_proto;
        n_csum    = r_csum;
        n_src     = r_src;
        n_dst     = r_dst;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_VER_IHL)) begin
            n_version = i_data_byte[7:4];
            n_ihl     = i_data_byte[3:0];
        end
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_TOTAL_HI)) n_total[15:8] = i_data_byte;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_TOTAL_LO)) n_total[7:0]  = i_data_byte;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_TTL))      n_ttl         = i_data_byte;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_PROTO))    n_proto       = i_data_byte;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_CSUM_HI))  n_csum[15:8]  = i_data_byte;
        if (pos == iphp_pkg::t_count'(iphp_pkg::OFS_CSUM_LO))  n_csum[7:0]   = i_data_byte;
        if (pos >= iphp_pkg::t_count'(iphp_pkg::OFS_SRC_LO) &&
            pos <= iphp_pkg::t_count'(iphp_pkg::OFS_SRC_HI)) begin
            n_src = {r_src[23:0], i_data_byte};
        end
        if (pos >= iphp_pkg::t_count'(iphp_pkg::OFS_DST_LO) &&
            pos <= iphp_pkg::t_count'(iphp_pkg::OFS_DST_HI)) begin
            n_dst = {r_dst[23:0], i_data_byte};
        end
    end

    assign hdr_len = {n_ihl, 2'b00};
    assign in_hdr  = !saturated && (pos < iphp_pkg::t_count'(hdr_len));

    // Ones'-complement accumulate on the odd byte of each 16-bit word
    assign sum_raw = {1'b0, r_sum} + {2'b00, r_hold, i_data_byte};

    always_comb begin
        n_hold = r_hold;
        n_sum  = r_sum;
        if (in_hdr) begin
            if (!pos[0]) begin
                n_hold = i_data_byte;
            end else if (sum_raw > 18'h0FFFF) begin
                n_sum = {1'b0, sum_raw[15:0]} + 17'd1;
            end else begin
                n_sum = sum_raw[16:0];
            end
        end
    end

    assign pay_len = (n_total >= 16'(hdr_len)) ? (n_total - 16'(hdr_len)) : 16'd0;

    assign pay_ok = !saturated && (n_version == iphp_pkg::IPV4_VERSION) &&
                    (n_ihl >= iphp_pkg::IHL_MIN) && (n_total >= 16'(hdr_len)) &&
                    (pay_len <= r_max_payload) && (pos >= iphp_pkg::t_count'(hdr_len)) &&
                    (pos < iphp_pkg::t_count'(n_total));

    assign frame_len = saturated ? pos : pos + iphp_pkg::t_count'(1);
    assign hdr_whole = (n_ihl >= iphp_pkg::IHL_MIN) &&
                       (frame_len >= iphp_pkg::t_count'(hdr_len));

    // First failing check wins
    always_comb begin
        if (frame_len < iphp_pkg::t_count'(iphp_pkg::MIN_HDR)) begin
            status = iphp_pkg::ST_SHORT;
        end else if (n_version != iphp_pkg::IPV4_VERSION) begin
            status = iphp_pkg::ST_VERSION;
        end else if (n_ihl < iphp_pkg::IHL_MIN) begin
            status = iphp_pkg::ST_IHL;
        end else if (frame_len < iphp_pkg::t_count'(hdr_len)) begin
            status = iphp_pkg::ST_HDR_PAST;
        end else if (n_total < 16'(hdr_len)) begin
            status = iphp_pkg::ST_TOTAL_SHORT;
        end else if (iphp_pkg::t_count'(n_total) > frame_len) begin
            status = iphp_pkg::ST_TOTAL_LONG;
        end else if (pay_len > r_max_payload) begin
            status = iphp_pkg::ST_PAY_LIMIT;
        end else begin
            status = iphp_pkg::ST_OK;
        end
    end

    assign o_push                         = take && (pay_ok || i_frame_last);
    assign o_entry.has_pay                = pay_ok;
    assign o_entry.has_sum                = i_frame_last;
    assign o_entry.pay_byte               = i_data_byte;
    assign o_entry.summary.status         = status;
    assign o_entry.summary.ttl            = n_ttl;
    assign o_entry.summary.protocol       = n_proto;
    assign o_entry.summary.src_address    = n_src;
    assign o_entry.summary.dst_address    = n_dst;
    assign o_entry.summary.header_checksum = n_csum;
    assign o_entry.summary.checksum_ok    = hdr_whole && (n_sum == 17'h0FFFF);
    assign o_entry.summary.payload_length = pay_len;
    assign o_entry.summary.header_length  = hdr_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= iphp_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_frame_last)) begin
            r_byte_count <= '0;
            r_version    <= '0;
            r_ihl        <= '0;
            r_total      <= '0;
            r_ttl        <= '0;
            r_proto      <= '0;
            r_csum       <= '0;
            r_src        <= '0;
            r_dst        <= '0;
            r_sum        <= '0;
            r_hold       <= '0;
        end else if (take) begin
            if (!saturated) r_byte_count <= pos + iphp_pkg::t_count'(1);
            r_version <= n_version;
            r_ihl     <= n_ihl;
            r_total   <= n_total;
            r_ttl     <= n_ttl;
            r_proto   <= n_proto;
            r_csum    <= n_csum;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_sum     <= n_sum;
            r_hold    <= n_hold;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/iphp_queue.sv */
`default_nettype none
module iphp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire iphp_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output iphp_pkg::t_entry      o_head,
    output logic                  o_empty,
    output logic                  o_full
);

    iphp_pkg::t_entry                 r_mem [iphp_pkg::QUEUE_DEPTH];
    logic [iphp_pkg::QUEUE_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [iphp_pkg::QUEUE_AW:0]      r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (iphp_pkg::QUEUE_AW+1)'(iphp_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/iphp_back.sv */
`default_nettype none
module iphp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire iphp_pkg::t_entry i_head,
    input  wire logic             i_ready,
    output logic                  o_pop,
    output logic                  o_valid,
    output iphp_pkg::t_result     o_result
);

    logic                 r_valid, n_valid;
    logic                 r_phase, n_phase;   // payload half of head already sent
    iphp_pkg::t_result    r_res, n_res;
    logic                 load;

    assign load = !r_valid || i_ready;

    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid;
        n_phase = r_phase;
        n_res   = r_res;
        if (load) begin
            if (i_empty) begin
                n_valid = 1'b0;
            end else begin
                n_valid = 1'b1;
                if (i_head.has_pay && !r_phase) begin
                    n_res.kind         = iphp_pkg::KIND_PAYLOAD;
                    n_res.payload_byte = i_head.pay_byte;
                    n_res.summary      = '0;
                    if (i_head.has_sum) n_phase = 1'b1;
                    else o_pop = 1'b1;
                end else begin
                    n_res.kind         = iphp_pkg::KIND_SUMMARY;
                    n_res.payload_byte = '0;
                    n_res.summary      = i_head.summary;
                    n_phase            = 1'b0;
                    o_pop              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule
`default_nettype wire

/* hw/rtl/ipv4_header_parser.sv */
// IPv4 header parser with header checksum check.
// Input channel (i_valid / o_ready): one frame byte per transaction, with
// i_frame_last on the final byte. Output channel (o_valid / i_ready): one
// result per transaction; o_kind 0 is a payload byte, o_kind 1 the frame
// summary, which always closes the frame's results.
// i_cfg_we / i_cfg_data write max_payload (reset 1480); write only when idle.
// Throughput: one byte per cycle while the queue is not full. The front
// updates fields, byte count and the ones'-complement sum for each byte;
// a frame whose last byte is also payload yields two results, and the
// 4-entry queue between front and back absorbs the extra result.
// Path: an accepted byte is written into the queue, then its result is
// loaded into the output register, from which the receiver takes it.
// Receiver stall: the output register holds; the queue keeps accepting until
// it has 4 entries, then o_ready drops. Bytes that produce no result (header,
// padding) are taken whenever the queue is not full.
// Reset (synchronous, active low): frame state, queue and output valid are
// cleared, max_payload returns to 1480.
`default_nettype none
module ipv4_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_last,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_status,
    output logic [7:0]       o_ttl,
    output logic [7:0]       o_protocol,
    output logic [31:0]      o_src_address,
    output logic [31:0]      o_dst_address,
    output logic [15:0]      o_header_checksum,
    output logic             o_checksum_ok,
    output logic [15:0]      o_payload_length,
    output logic [5:0]       o_header_length
);

    iphp_pkg::t_entry  push_entry, head_entry;
    iphp_pkg::t_result result;
    logic              push, pop, q_empty, q_full;

    // Front: byte accept, field capture, checksum, classification
    iphp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_full       (q_full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Decoupling queue; each entry holds a payload byte, a summary, or both
    iphp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: splits entries into results, payload before summary
    iphp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head_entry),
        .i_ready  (i_ready),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_kind            = result.kind;
    assign o_payload_byte    = result.payload_byte;
    assign o_status          = result.summary.status;
    assign o_ttl             = result.summary.ttl;
    assign o_protocol        = result.summary.protocol;
    assign o_src_address     = result.summary.src_address;
    assign o_dst_address     = result.summary.dst_address;
    assign o_header_checksum = result.summary.header_checksum;
    assign o_checksum_ok     = result.summary.checksum_ok;
    assign o_payload_length  = result.summary.payload_length;
    assign o_header_length   = result.summary.header_length;

endmodule
`default_nettype wire

/* hw/rtl/iphp_checker.sv */
`default_nettype none
module iphp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_kind,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_ttl,
    input wire logic [15:0] o_header_checksum,
    input wire logic        o_checksum_ok,
    input wire logic [15:0] o_payload_length,
    input wire logic [5:0]  o_header_length
);

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // Payload transactions carry no summary content
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == iphp_pkg::KIND_PAYLOAD) |->
        (o_status == iphp_pkg::ST_OK) && (o_ttl == 8'd0) &&
        (o_header_checksum == 16'd0) && !o_checksum_ok &&
        (o_payload_length == 16'd0) && (o_header_length == 6'd0))
        else $error("payload result with summary fields");

    // A good checksum needs a full header of at least 20 bytes
    a_summary_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == iphp_pkg::KIND_SUMMARY) |->
        (o_payload_byte == 8'd0) &&
        (!o_checksum_ok || (o_header_length >= 6'(iphp_pkg::MIN_HDR))))
        else $error("inconsistent summary");

endmodule

bind ipv4_header_parser iphp_checker u_checker (.*);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    // One directed frame: header fields, bytes actually sent, and an optional
    // pinned status code. All other summary fields come from the predictor.
    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] total;
        logic [16:0] flen;
        logic        good_sum;
        logic        pinned;
        logic [2:0]  st;
    } t_frame_row;

    localparam int NUM_ROWS   = 17;
    localparam int LONG_HOLD  = 300;   // receiver hold-off, in cycles
    localparam int PHASE_LEN  = 240;   // random bytes per config setting
    localparam int DRAIN_WAIT = 4;     // settle time after the last result

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_last = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_ttl;
    logic [7:0]  o_protocol;
    logic [31:0] o_src_address;
    logic [31:0] o_dst_address;
    logic [15:0] o_header_checksum;
    logic        o_checksum_ok;
    logic [15:0] o_payload_length;
    logic [5:0]  o_header_length;

    ipv4_header_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_frame_last      (i_frame_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_status          (o_status),
        .o_ttl             (o_ttl),
        .o_protocol        (o_protocol),
        .o_src_address     (o_src_address),
        .o_dst_address     (o_dst_address),
        .o_header_checksum (o_header_checksum),
        .o_checksum_ok     (o_checksum_ok),
        .o_payload_length  (o_payload_length),
        .o_header_length   (o_header_length)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Parser shadow state (reset values) and the results it still owes
    // ---------------------------------------------------------------------
    logic [15:0]      max_payload_cfg = iphp_pkg::MAX_PAYLOAD_RST;
    iphp_pkg::t_count pf_count = '0;
    logic [3:0]       pf_ver = '0;
    logic [3:0]       pf_ihl = '0;
    logic [15:0]      pf_total = '0;
    logic [7:0]       pf_ttl = '0;
    logic [7:0]       pf_proto = '0;
    logic [15:0]      pf_csum = '0;
    logic [31:0]      pf_src = '0;
    logic [31:0]      pf_dst = '0;
    logic [16:0]      pf_sum = '0;
    logic [7:0]       pf_hold = '0;

    iphp_pkg::t_result awaited[$];

    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    logic        calm = 1'b0;          // no idling on either side
    logic        long_hold_req = 1'b0;

    t_frame_row  directed_rows [NUM_ROWS];

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Advance the parser by one accepted byte and queue what it owes.
    // A pinned status replaces the computed one in the frame summary.
    task automatic predict_parse(input logic [7:0] b, input logic last,
                                 input logic pin, input logic [2:0] pin_st);
        iphp_pkg::t_result r;
        int unsigned       pos, hdr_len, pay_len, frame_len;
        logic [17:0]       s;
        logic              sat;
        logic [2:0]        st;

        pos = 32'(pf_count);
        sat = (pf_count == iphp_pkg::COUNT_MAX);
        if (pos == iphp_pkg::OFS_VER_IHL) begin
            pf_ver = b[7:4];
            pf_ihl = b[3:0];
        end
        hdr_len = pf_ihl * 4;

        case (pos)
            iphp_pkg::OFS_TOTAL_HI: pf_total[15:8] = b;
            iphp_pkg::OFS_TOTAL_LO: pf_total[7:0]  = b;
            iphp_pkg::OFS_TTL:      pf_ttl         = b;
            iphp_pkg::OFS_PROTO:    pf_proto       = b;
            iphp_pkg::OFS_CSUM_HI:  pf_csum[15:8]  = b;
            iphp_pkg::OFS_CSUM_LO:  pf_csum[7:0]   = b;
            default: ;
        endcase
        if (pos >= iphp_pkg::OFS_SRC_LO && pos <= iphp_pkg::OFS_SRC_HI)
            pf_src = {pf_src[23:0], b};
        if (pos >= iphp_pkg::OFS_DST_LO && pos <= iphp_pkg::OFS_DST_HI)
            pf_dst = {pf_dst[23:0], b};

        // 16-bit words over the header, end-around carry
        if (!sat && pos < hdr_len) begin
            if (pos[0] == 1'b0) begin
                pf_hold = b;
            end else begin
                s = pf_sum + {pf_hold, b};
                if (s > 18'h0FFFF)
                    s = s[15:0] + 1'b1;
                pf_sum = s[16:0];
            end
        end

        pay_len = (pf_total >= hdr_len) ? pf_total - hdr_len : 0;

        if (!sat && pf_ver == iphp_pkg::IPV4_VERSION && pf_ihl >= iphp_pkg::IHL_MIN &&
            pf_total >= hdr_len && pay_len <= max_payload_cfg &&
            pos >= hdr_len && pos < pf_total) begin
            r = '0;
            r.kind = iphp_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            awaited.push_back(r);
        end

        if (!sat)
            pf_count = pf_count + 1'b1;

        if (last) begin
            frame_len = 32'(pf_count);
            if (frame_len < iphp_pkg::MIN_HDR)             st = iphp_pkg::ST_SHORT;
            else if (pf_ver != iphp_pkg::IPV4_VERSION)     st = iphp_pkg::ST_VERSION;
            else if (pf_ihl < iphp_pkg::IHL_MIN)           st = iphp_pkg::ST_IHL;
            else if (hdr_len > frame_len)                  st = iphp_pkg::ST_HDR_PAST;
            else if (pf_total < hdr_len)                   st = iphp_pkg::ST_TOTAL_SHORT;
            else if (pf_total > frame_len)                 st = iphp_pkg::ST_TOTAL_LONG;
            else if (pay_len > max_payload_cfg)            st = iphp_pkg::ST_PAY_LIMIT;
            else                                           st = iphp_pkg::ST_OK;
            if (pin)
                st = pin_st;

            r = '0;
            r.kind = iphp_pkg::KIND_SUMMARY;
            r.summary.status = st;
            r.summary.ttl = pf_ttl;
            r.summary.protocol = pf_proto;
            r.summary.src_address = pf_src;
            r.summary.dst_address = pf_dst;
            r.summary.header_checksum = pf_csum;
            r.summary.checksum_ok = (pf_ihl >= iphp_pkg::IHL_MIN) &&
                                    (frame_len >= hdr_len) && (pf_sum == 17'h0FFFF);
            r.summary.payload_length = pay_len[15:0];
            r.summary.header_length = hdr_len[5:0];
            awaited.push_back(r);

            // frame state clears after the summary
            pf_count = '0;
            pf_ver   = '0;
            pf_ihl   = '0;
            pf_total = '0;
            pf_ttl   = '0;
            pf_proto = '0;
            pf_csum  = '0;
            pf_src   = '0;
            pf_dst   = '0;
            pf_sum   = '0;
            pf_hold  = '0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Input side: one byte per transaction, random gap bursts ahead of it
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic pin, input logic [2:0] pin_st);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_frame_last <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        predict_parse(b, last, pin, pin_st);
    endtask

    // Build a frame with random contents around the given header fields.
    // A good checksum is only meaningful with a legal IHL.
    task automatic send_frame(input logic [3:0] ver, input logic [3:0] ihl,
                              input int unsigned total, input int unsigned flen,
                              input logic good_sum, input logic pin,
                              input logic [2:0] pin_st);
        logic [7:0]  frm [];
        logic [16:0] acc;
        int unsigned hlen, nb, k;

        hlen = ihl * 4;
        nb = (flen > hlen) ? flen : hlen;
        if (nb < iphp_pkg::MIN_HDR)
            nb = iphp_pkg::MIN_HDR;
        frm = new[nb];
        for (k = 0; k < nb; k++)
            frm[k] = 8'($urandom);
        frm[iphp_pkg::OFS_VER_IHL]  = {ver, ihl};
        frm[iphp_pkg::OFS_TOTAL_HI] = total[15:8];
        frm[iphp_pkg::OFS_TOTAL_LO] = total[7:0];
        if (good_sum && hlen >= iphp_pkg::MIN_HDR) begin
            frm[iphp_pkg::OFS_CSUM_HI] = 8'h00;
            frm[iphp_pkg::OFS_CSUM_LO] = 8'h00;
            acc = '0;
            for (k = 0; k + 1 < hlen; k = k + 2) begin
                acc = acc + {frm[k], frm[k+1]};
                if (acc[16])
                    acc = acc[15:0] + 1'b1;
            end
            {frm[iphp_pkg::OFS_CSUM_HI], frm[iphp_pkg::OFS_CSUM_LO]} = ~acc[15:0];
        end
        for (k = 0; k < flen; k++)
            push_byte(frm[k], k == flen - 1, pin, pin_st);
    endtask

    // Mostly clean frames with random content; the rest truncated,
    // inconsistent in total length, or plain noise.
    task automatic send_random_frame();
        int unsigned sel, ihl, total, flen;
        logic [3:0]  ver;

        sel = $urandom_range(0, 99);
        ver = iphp_pkg::IPV4_VERSION;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        total = ihl * 4 + $urandom_range(0, 48);
        flen = total;
        if (sel < 75) begin
            if ($urandom_range(0, 3) == 0)
                flen = total + $urandom_range(1, 6);
        end else if (sel < 88) begin
            flen = $urandom_range(1, total);
        end else if (sel < 94) begin
            total = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, ihl * 4 + 50);
            flen = ihl * 4 + $urandom_range(0, 40);
        end else begin
            ver = 4'($urandom_range(0, 15));
            ihl = $urandom_range(0, 15);
            total = $urandom_range(0, 65535);
            flen = $urandom_range(1, 80);
        end
        send_frame(ver, ihl[3:0], total, flen, $urandom_range(0, 9) != 0, 1'b0,
                   iphp_pkg::ST_OK);
    endtask

    // Config writes only with the parser idle: every owed result taken first.
    task automatic set_max_payload(input logic [15:0] v);
        i_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_payload_cfg = v;
    endtask

    // ---------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string nm, input logic [31:0] e,
                               input logic [31:0] a);
        if (e !== a)
            report_error($sformatf("%s: expected 0x%0h, got 0x%0h", nm, e, a));
    endtask

    // Every result transaction is matched against the oldest owed result
    always @(posedge i_clk) begin : result_check
        iphp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited.size() == 0) begin
                report_error($sformatf("result with nothing owed (kind %0d)", o_kind));
            end else begin
                want = awaited.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("status", 32'(want.summary.status), 32'(o_status));
                check_field("ttl", 32'(want.summary.ttl), 32'(o_ttl));
                check_field("protocol", 32'(want.summary.protocol), 32'(o_protocol));
                check_field("src_address", want.summary.src_address, o_src_address);
                check_field("dst_address", want.summary.dst_address, o_dst_address);
                check_field("header_checksum", 32'(want.summary.header_checksum),
                            32'(o_header_checksum));
                check_field("checksum_ok", 32'(want.summary.checksum_ok),
                            32'(o_checksum_ok));
                check_field("payload_length", 32'(want.summary.payload_length),
                            32'(o_payload_length));
                check_field("header_length", 32'(want.summary.header_length),
                            32'(o_header_length));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int          k, w;
        int unsigned phase_end;

        //                ver    ihl    total      bytes      csum  pin   status
        directed_rows = '{
            '{4'd4,  4'd5,  16'd20,    17'd20,    1'b1, 1'b1, iphp_pkg::ST_OK},    // minimal
            // payload at the reset limit is passed, one past it is held back
            '{4'd4,  4'd5,  16'd1500,  17'd60,    1'b1, 1'b1, iphp_pkg::ST_TOTAL_LONG},
            '{4'd4,  4'd5,  16'd1501,  17'd60,    1'b1, 1'b1, iphp_pkg::ST_TOTAL_LONG},
            '{4'd4,  4'd5,  16'd20,    17'd1,     1'b1, 1'b1, iphp_pkg::ST_SHORT}, // one byte
            '{4'd4,  4'd5,  16'd20,    17'd19,    1'b1, 1'b1, iphp_pkg::ST_SHORT},
            '{4'd6,  4'd5,  16'd40,    17'd40,    1'b1, 1'b1, iphp_pkg::ST_VERSION},
            '{4'd4,  4'd4,  16'd40,    17'd40,    1'b1, 1'b1, iphp_pkg::ST_IHL},
            '{4'd4,  4'd0,  16'd40,    17'd40,    1'b0, 1'b1, iphp_pkg::ST_IHL},
            // odd tail
            '{4'd4,  4'd15, 16'd100,   17'd41,    1'b1, 1'b1, iphp_pkg::ST_HDR_PAST},
            '{4'd4,  4'd15, 16'd80,    17'd80,    1'b1, 1'b1, iphp_pkg::ST_OK},    // options
            '{4'd4,  4'd6,  16'd20,    17'd30,    1'b1, 1'b1, iphp_pkg::ST_TOTAL_SHORT},
            // bytes already sent are kept
            '{4'd4,  4'd5,  16'd100,   17'd60,    1'b1, 1'b1, iphp_pkg::ST_TOTAL_LONG},
            '{4'd4,  4'd5,  16'd40,    17'd50,    1'b1, 1'b1, iphp_pkg::ST_OK},    // padding
            '{4'd4,  4'd5,  16'd30,    17'd30,    1'b0, 1'b0, iphp_pkg::ST_OK},    // bad sum
            '{4'd15, 4'd15, 16'hFFFF,  17'd20,    1'b1, 1'b1, iphp_pkg::ST_VERSION},
            '{4'd0,  4'd0,  16'd0,     17'd20,    1'b0, 1'b1, iphp_pkg::ST_VERSION},
            '{4'd4,  4'd5,  16'hFFFF,  17'd60,    1'b1, 1'b1, iphp_pkg::ST_TOTAL_LONG}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames under the reset value of max_payload
        for (k = 0; k < NUM_ROWS; k++)
            send_frame(directed_rows[k].ver, directed_rows[k].ihl,
                       32'(directed_rows[k].total), 32'(directed_rows[k].flen),
                       directed_rows[k].good_sum, directed_rows[k].pinned,
                       directed_rows[k].st);

        // zero payload limit: only an empty payload passes
        set_max_payload(16'd0);
        send_frame(iphp_pkg::IPV4_VERSION, iphp_pkg::IHL_MIN, 20, 20, 1'b1, 1'b1,
                   iphp_pkg::ST_OK);
        send_frame(iphp_pkg::IPV4_VERSION, iphp_pkg::IHL_MIN, 21, 21, 1'b1, 1'b1,
                   iphp_pkg::ST_PAY_LIMIT);

        // largest limit; the receiver holds off at the start of a long
        // payload so the queue fills and the input stalls
        set_max_payload(16'd65515);
        long_hold_req = 1'b1;
        send_frame(iphp_pkg::IPV4_VERSION, iphp_pkg::IHL_MIN, 200, 200, 1'b1, 1'b1,
                   iphp_pkg::ST_OK);

        // random frames across several limits
        set_max_payload(16'd16);
        phase_end = bytes_sent + PHASE_LEN;
        while (bytes_sent < phase_end) send_random_frame();

        set_max_payload(16'($urandom_range(0, 65515)));
        phase_end = bytes_sent + PHASE_LEN;
        while (bytes_sent < phase_end) send_random_frame();

        set_max_payload(16'd44);
        phase_end = bytes_sent + PHASE_LEN;
        while (bytes_sent < phase_end) send_random_frame();

        // last stretch back to back, no idling on either side
        set_max_payload(16'd65515);
        calm = 1'b1;
        phase_end = bytes_sent + PHASE_LEN;
        while (bytes_sent < phase_end) send_random_frame();
        i_valid <= 1'b0;

        for (w = 0; w < 100000 && awaited.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (awaited.size() != 0)
            report_error($sformatf("%0d results never arrived", awaited.size()));

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit, well above the slowest legal run
    initial begin : watchdog
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* ipv4_header_parser.f */
hw/rtl/iphp_pkg.sv
hw/rtl/iphp_front.sv
hw/rtl/iphp_queue.sv
hw/rtl/iphp_back.sv
hw/rtl/ipv4_header_parser.sv
hw/rtl/iphp_checker.sv
dv/tb.sv
